/* rtl/fds_pkg.sv */
// ----------------------------------------------------------------------------
// Fractional downsampler package
// Widths, codes, controller types and the saturation helper shared by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package fds_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int RATE_W      = 8;
  localparam int VALUE_W     = 24;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = RATE_W;

  // The quotient is worked out three bits a cycle over the whole word.
  localparam int DIV_BITS_PER_CYCLE = 3;
  localparam int DIV_CYCLES         = VALUE_W / DIV_BITS_PER_CYCLE;
  localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

  localparam logic [CFG_INDEX_W-1:0] CFG_IN_RATE  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUT_RATE = 1'b1;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic mul;
    logic div_step;
    logic commit_acc;
    logic commit_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_flush;
    logic rate_bad;
    logic no_emit;
    logic div_last;
  } ctrl_status_t;

  function automatic logic signed [VALUE_W-1:0] sat_value(
    input logic signed [VALUE_W+1:0] v
  );
    logic signed [VALUE_W+1:0] hi;
    logic signed [VALUE_W+1:0] lo;
    lo = {{2{1'b1}}, VALUE_MIN};
    hi = {2'b00, VALUE_MAX};
    if (v > hi) begin
      return VALUE_MAX;
    end else if (v < lo) begin
      return VALUE_MIN;
    end
    return v[VALUE_W-1:0];
  endfunction

endpackage

/* rtl/fds_if.sv */
// ----------------------------------------------------------------------------
// Fractional downsampler channels
// Valid/ready channels for input requests and for results.
// ----------------------------------------------------------------------------
interface fds_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 command;
  logic signed [fds_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output command, output sample, input ready);
  modport sink   (input valid, input command, input sample, output ready);
endinterface

interface fds_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fds_pkg::VALUE_W-1:0]   value;
  logic                                 from_flush;
  logic                                 rate_error;

  modport source (output valid, output value, output from_flush, output rate_error,
                  input ready);
  modport sink   (input valid, input value, input from_flush, input rate_error,
                  output ready);
endinterface

/* rtl/fds_ctrl.sv */
// ----------------------------------------------------------------------------
// Fractional downsampler controller
// Sequences each request through evaluation and, as needed, multiply, divide
// and result, and owns the result valid flag.
// ----------------------------------------------------------------------------
module fds_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  fds_pkg::ctrl_status_t status,
  output fds_pkg::ctrl_cmd_t    cmd
);

  fds_pkg::state_t state;
  fds_pkg::state_t state_next;
  logic            out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fds_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fds_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = fds_pkg::ST_EVAL;
        end
      end
      fds_pkg::ST_EVAL: begin
        if (status.is_flush || status.rate_bad) begin
          state_next = fds_pkg::ST_RESULT;
        end else if (status.no_emit) begin
          state_next = fds_pkg::ST_IDLE;
        end else begin
          state_next = fds_pkg::ST_MUL;
        end
      end
      fds_pkg::ST_MUL: begin
        state_next = fds_pkg::ST_DIV;
      end
      fds_pkg::ST_DIV: begin
        if (status.div_last) begin
          state_next = fds_pkg::ST_RESULT;
        end
      end
      fds_pkg::ST_RESULT: begin
        if (out_free) begin
          state_next = fds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fds_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    case (state)
      fds_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      fds_pkg::ST_EVAL: begin
        cmd.eval       = 1'b1;
        cmd.commit_acc = !status.is_flush && !status.rate_bad && status.no_emit;
      end
      fds_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
      end
      fds_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      fds_pkg::ST_RESULT: begin
        cmd.commit_out = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/fds_datapath.sv */
// ----------------------------------------------------------------------------
// Fractional downsampler datapath
// Rate registers, running sum and fill level, the share multiplier, a
// three-bit-a-cycle restoring divider and the result register.
// ----------------------------------------------------------------------------
module fds_datapath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [fds_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [fds_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic                                    in_command,
  input  logic signed [fds_pkg::SAMPLE_W-1:0]     in_sample,
  input  fds_pkg::ctrl_cmd_t                      cmd,
  output fds_pkg::ctrl_status_t                   status,
  output logic signed [fds_pkg::VALUE_W-1:0]      out_value,
  output logic                                    out_from_flush,
  output logic                                    out_rate_error
);

  localparam int RW = fds_pkg::RATE_W;
  localparam int VW = fds_pkg::VALUE_W;
  localparam int SW = fds_pkg::SAMPLE_W;

  logic [RW-1:0]                  in_rate;
  logic [RW-1:0]                  out_rate;
  logic signed [VW-1:0]           running_sum;
  logic [RW-1:0]                  fill_level;

  logic                           command_r;
  logic signed [SW-1:0]           sample_r;
  logic [RW-1:0]                  spill;
  logic                           neg;
  logic [RW-1:0]                  rem;
  logic [VW-1:0]                  dq;
  logic [fds_pkg::DIV_CNT_W-1:0]  div_cnt;

  logic [RW:0]                    fill_sum;
  logic [RW:0]                    spill_raw;
  logic [RW-1:0]                  spill_lim;
  logic signed [SW+RW:0]          prod;
  logic [SW+RW:0]                 prod_mag;
  logic [RW-1:0]                  rem_next;
  logic [VW-1:0]                  dq_next;
  logic [RW:0]                    trial;
  logic signed [VW-1:0]           share;
  logic signed [VW+1:0]           emit_sum;
  logic signed [VW+1:0]           acc_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_rate  <= RW'(1);
      out_rate <= RW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        fds_pkg::CFG_IN_RATE:  in_rate  <= cfg_data;
        fds_pkg::CFG_OUT_RATE: out_rate <= cfg_data;
        default: begin
          in_rate <= in_rate;
        end
      endcase
    end
  end

  assign fill_sum  = {1'b0, fill_level} + {1'b0, out_rate};
  assign spill_raw = fill_sum - {1'b0, in_rate};
  assign spill_lim = (spill_raw > {1'b0, out_rate}) ? out_rate : spill_raw[RW-1:0];

  assign status.is_flush = (command_r == fds_pkg::CMD_FLUSH);
  assign status.rate_bad = (out_rate == '0) || (out_rate > in_rate);
  assign status.no_emit  = fill_sum < {1'b0, in_rate};
  assign status.div_last = (div_cnt == fds_pkg::DIV_CNT_W'(fds_pkg::DIV_CYCLES - 1));

  assign prod     = sample_r * $signed({1'b0, spill});
  assign prod_mag = prod[SW+RW] ? (SW+RW+1)'(-prod) : prod;

  always_comb begin
    rem_next = rem;
    dq_next  = dq;
    trial    = '0;
    for (int i = 0; i < fds_pkg::DIV_BITS_PER_CYCLE; i++) begin
      trial   = {rem_next, dq_next[VW-1]};
      dq_next = {dq_next[VW-2:0], 1'b0};
      if (trial >= {1'b0, out_rate}) begin
        rem_next   = RW'(trial - {1'b0, out_rate});
        dq_next[0] = 1'b1;
      end else begin
        rem_next = trial[RW-1:0];
      end
    end
  end

  assign share    = neg ? -$signed(dq) : $signed(dq);
  assign emit_sum = (VW+2)'(running_sum) + (VW+2)'(sample_r) - (VW+2)'(share);
  assign acc_sum  = (VW+2)'(running_sum) + (VW+2)'(sample_r);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      command_r <= in_command;
      sample_r  <= in_sample;
    end
    if (cmd.eval) begin
      spill <= spill_lim;
    end
    if (cmd.mul) begin
      neg     <= prod[SW+RW];
      dq      <= VW'(prod_mag);
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      dq      <= dq_next;
      rem     <= rem_next;
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.commit_out) begin
      if (status.is_flush) begin
        out_value      <= running_sum;
        out_from_flush <= 1'b1;
        out_rate_error <= 1'b0;
      end else if (status.rate_bad) begin
        out_value      <= '0;
        out_from_flush <= 1'b0;
        out_rate_error <= 1'b1;
      end else begin
        out_value      <= fds_pkg::sat_value(emit_sum);
        out_from_flush <= 1'b0;
        out_rate_error <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      fill_level  <= '0;
    end else if (cmd.commit_acc) begin
      running_sum <= fds_pkg::sat_value(acc_sum);
      fill_level  <= fill_sum[RW-1:0];
    end else if (cmd.commit_out) begin
      if (status.is_flush) begin
        running_sum <= '0;
        fill_level  <= '0;
      end else if (!status.rate_bad) begin
        running_sum <= share;
        fill_level  <= spill;
      end
    end
  end

endmodule

/* rtl/fractional_downsampler.sv */
// ----------------------------------------------------------------------------
// Fractional downsampler
// Integrate-and-dump decimator by in_rate over out_rate, without
// normalisation, for signed 16-bit samples.
//
// Requests arrive on in_ch: command selects a new sample or a flush of the
// running sum. Results leave on out_ch with a flush mark and a rate error
// mark. Both channels move a request when valid and ready are high together.
// The user must write the rate registers through cfg_we, cfg_index and
// cfg_data only while the block is idle; the block itself does not enforce it.
// A sample that completes an output passes from acceptance through evaluation,
// the multiply state and the restoring divider, which yields three quotient
// bits a cycle, to the result state; the next request is taken after that.
// A sample that only accumulates returns to idle from evaluation; a flush or
// a rate error goes from evaluation straight to the result state.
// Reset clears the sum and fill level and sets both rates to one.
// A stalled receiver holds the result in the output register; the next
// request is still taken and worked on, waiting only to deliver its result.
// ----------------------------------------------------------------------------
module fractional_downsampler (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [fds_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fds_pkg::CFG_DATA_W-1:0]     cfg_data,
  fds_in_if.sink                             in_ch,
  fds_out_if.source                          out_ch
);

  fds_pkg::ctrl_cmd_t    cmd;
  fds_pkg::ctrl_status_t status;

  fds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  fds_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_command     (in_ch.command),
    .in_sample      (in_ch.sample),
    .cmd            (cmd),
    .status         (status),
    .out_value      (out_ch.value),
    .out_from_flush (out_ch.from_flush),
    .out_rate_error (out_ch.rate_error)
  );

endmodule

/* rtl/fds_checker.sv */
// ----------------------------------------------------------------------------
// Fractional downsampler checker
// Port-level assertions on requests and results, bound to the top level.
// ----------------------------------------------------------------------------
module fds_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [fds_pkg::VALUE_W-1:0]  value,
  input logic                                from_flush,
  input logic                                rate_error
);

  // A rate error result carries a zero value and is never a flush.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && rate_error |-> (value == '0) && !from_flush)
    else $error("rate error result with non-zero value or flush mark");

  // One request at a time: ready drops in the cycle after an acceptance.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while the previous one is in progress");

  // No result is shown in the cycle after reset.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(from_flush)
      && $stable(rate_error))
    else $error("stalled result changed");

endmodule

bind fractional_downsampler fds_checker u_fds_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .value      (out_ch.value),
  .from_flush (out_ch.from_flush),
  .rate_error (out_ch.rate_error)
);

/* verif/fractional_downsampler_checker.sv */
// ----------------------------------------------------------------------------
// Fractional downsampler checker
// Watches the rate register writes and both channels, keeps its own
// running sum and fill level, works out the result due, if any, for every
// accepted input request and compares each delivered result field by field with the
// oldest one still due. Mismatches and the number of results still due are
// handed to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fractional_downsampler_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fds_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fds_pkg::CFG_DATA_W-1:0]  cfg_data,
  fds_in_if                               in_ch,
  fds_out_if                              out_ch,
  output int                              mismatches,
  output int                              outstanding
);

  typedef struct packed {
    logic signed [fds_pkg::VALUE_W-1:0] value;
    logic                               from_flush;
    logic                               rate_error;
  } dump_t;

  logic [fds_pkg::RATE_W-1:0]         rate_in;
  logic [fds_pkg::RATE_W-1:0]         rate_out;
  logic signed [fds_pkg::VALUE_W-1:0] acc_sum;
  logic [fds_pkg::RATE_W-1:0]         acc_fill;
  dump_t                              due_dumps[$];
  int                                 mismatch_total;
  int                                 dumps_seen;

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %0s", $realtime, what);
    mismatch_total++;
  endtask

  function automatic logic signed [fds_pkg::VALUE_W-1:0] clamp_value(input longint v);
    if (v > longint'(fds_pkg::VALUE_MAX)) begin
      return fds_pkg::VALUE_MAX;
    end
    if (v < longint'(fds_pkg::VALUE_MIN)) begin
      return fds_pkg::VALUE_MIN;
    end
    return v[fds_pkg::VALUE_W-1:0];
  endfunction

  // Returns one when the request produces a result, which is left in res.
  function automatic bit downsample_step(input logic cmd,
                                         input logic signed [fds_pkg::SAMPLE_W-1:0] smp,
                                         output dump_t res);
    int s;
    int step_size;
    int limit;
    int fill;
    int spill;
    int held;
    s         = smp;
    step_size = rate_out;
    limit     = rate_in;
    res       = '0;
    if (cmd == fds_pkg::CMD_FLUSH) begin
      res.value      = acc_sum;
      res.from_flush = 1'b1;
      acc_sum        = '0;
      acc_fill       = '0;
      return 1'b1;
    end
    if (step_size == 0 || step_size > limit) begin
      res.rate_error = 1'b1;
      return 1'b1;
    end
    fill = acc_fill;
    fill = fill + step_size;
    if (fill < limit) begin
      acc_sum  = clamp_value(longint'(acc_sum) + s);
      acc_fill = fill[fds_pkg::RATE_W-1:0];
      return 1'b0;
    end
    // A fill level left high by a rate change never holds back more than
    // the whole sample.
    spill = fill - limit;
    if (spill > step_size) begin
      spill = step_size;
    end
    held      = (s * spill) / step_size;
    res.value = clamp_value(longint'(acc_sum) + s - held);
    acc_sum   = held[fds_pkg::VALUE_W-1:0];
    acc_fill  = spill[fds_pkg::RATE_W-1:0];
    return 1'b1;
  endfunction

  always @(posedge clk) begin : track
    dump_t got;
    dump_t want;
    dump_t fresh;
    if (rst) begin
      rate_in  = 8'd1;
      rate_out = 8'd1;
      acc_sum  = '0;
      acc_fill = '0;
      due_dumps.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fds_pkg::CFG_IN_RATE:  rate_in = cfg_data;
          fds_pkg::CFG_OUT_RATE: rate_out = cfg_data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got.value      = out_ch.value;
        got.from_flush = out_ch.from_flush;
        got.rate_error = out_ch.rate_error;
        dumps_seen++;
        if (due_dumps.size() == 0) begin
          report_mismatch($sformatf("result %0d (value %0d) arrived with none due",
                                    dumps_seen, got.value));
        end else begin
          want = due_dumps.pop_front();
          if (got.value !== want.value) begin
            report_mismatch($sformatf("result %0d value %0d, expected %0d",
                                      dumps_seen, got.value, want.value));
          end
          if (got.from_flush !== want.from_flush) begin
            report_mismatch($sformatf("result %0d from_flush %b, expected %b",
                                      dumps_seen, got.from_flush, want.from_flush));
          end
          if (got.rate_error !== want.rate_error) begin
            report_mismatch($sformatf("result %0d rate_error %b, expected %b",
                                      dumps_seen, got.rate_error, want.rate_error));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (downsample_step(in_ch.command, in_ch.sample, fresh)) begin
          due_dumps.push_back(fresh);
        end
      end
    end
    outstanding <= due_dumps.size();
    mismatches  <= mismatch_total;
  end

endmodule

/* verif/tb_fractional_downsampler.sv */
// ----------------------------------------------------------------------------
// Fractional downsampler testbench
// Drives sample and flush requests in bursts under a range of rate settings,
// including the extremes, bad rates and a fill level left high by a rate
// change, while the result side stalls on a pattern of its own. A checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fractional_downsampler;

  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 16;

  localparam logic signed [fds_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [fds_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_SELDOM,
    RX_TOGGLE
  } rx_mode_t;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [fds_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [fds_pkg::CFG_DATA_W-1:0]  cfg_data;
  int                              mismatches;
  int                              outstanding;
  int                              holds_asked;
  int                              holds_done;
  int                              hold_left;
  int                              mode_left;
  rx_mode_t                        rx_mode;
  int unsigned                     stall_cycles;

  fds_in_if  in_ch ();
  fds_out_if out_ch ();

  fractional_downsampler i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  fractional_downsampler_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      holds_done   <= 0;
      hold_left    <= 0;
      mode_left    <= 0;
      rx_mode      <= RX_ALWAYS;
    end else if (holds_done != holds_asked) begin
      holds_done   <= holds_asked;
      hold_left    <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(8, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_ALWAYS: out_ch.ready <= 1'b1;
        RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_SELDOM: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:   out_ch.ready <= ~out_ch.ready;
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_request(input logic cmd,
                              input logic signed [fds_pkg::SAMPLE_W-1:0] smp);
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.sample  <= smp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic pause(input int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_rates(input logic [fds_pkg::RATE_W-1:0] in_value,
                           input logic [fds_pkg::RATE_W-1:0] out_value);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= fds_pkg::CFG_IN_RATE;
    cfg_data  <= in_value;
    @(posedge clk);
    cfg_index <= fds_pkg::CFG_OUT_RATE;
    cfg_data  <= out_value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [fds_pkg::SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      3:       return '1;
      default: return fds_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_random_items(input int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      if (burst > left) begin
        burst = left;
      end
      repeat (burst) begin
        send_request(($urandom_range(0, 15) == 0) ? fds_pkg::CMD_FLUSH : fds_pkg::CMD_SAMPLE,
                     random_sample());
      end
      left -= burst;
      if ($urandom_range(0, 3) != 0) begin
        pause($urandom_range(1, 20));
      end
    end
  endtask

  initial begin : stimulus
    int in_value;
    int out_value;
    int pick;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = fds_pkg::CFG_IN_RATE;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.command = fds_pkg::CMD_SAMPLE;
    in_ch.sample  = '0;
    holds_asked   = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_request(fds_pkg::CMD_SAMPLE, SAMPLE_MAX);
    send_request(fds_pkg::CMD_SAMPLE, SAMPLE_MIN);
    send_request(fds_pkg::CMD_SAMPLE, '1);
    send_request(fds_pkg::CMD_FLUSH, '0);
    send_request(fds_pkg::CMD_FLUSH, SAMPLE_MAX);
    set_rates(8'd3, 8'd2);
    send_request(fds_pkg::CMD_SAMPLE, SAMPLE_MIN);
    send_request(fds_pkg::CMD_SAMPLE, 16'sh8001);
    send_request(fds_pkg::CMD_SAMPLE, SAMPLE_MAX);
    send_request(fds_pkg::CMD_SAMPLE, SAMPLE_MAX);
    // A flush empties the sum even while the rates are bad.
    set_rates(8'd1, 8'd255);
    send_request(fds_pkg::CMD_SAMPLE, SAMPLE_MAX);
    send_request(fds_pkg::CMD_FLUSH, '0);
    set_rates(8'd255, 8'd255);
    send_request(fds_pkg::CMD_SAMPLE, SAMPLE_MAX);
    send_request(fds_pkg::CMD_SAMPLE, SAMPLE_MIN);
    set_rates(8'd255, 8'd254);
    send_request(fds_pkg::CMD_SAMPLE, SAMPLE_MIN);
    // The fill level now lies far above the new input rate.
    set_rates(8'd5, 8'd4);
    send_request(fds_pkg::CMD_SAMPLE, SAMPLE_MAX);
    send_request(fds_pkg::CMD_SAMPLE, SAMPLE_MIN);
    send_request(fds_pkg::CMD_FLUSH, '0);

    for (int phase = 0; phase < 24; phase++) begin
      case (phase)
        0: begin
          in_value  = 255;
          out_value = 255;
        end
        1: begin
          in_value  = 255;
          out_value = 1;
        end
        2: begin
          in_value  = 1;
          out_value = 1;
        end
        3: begin
          in_value  = 200;
          out_value = 255;
        end
        default: begin
          pick = $urandom_range(0, 5);
          if (pick == 0) begin
            in_value  = $urandom_range(1, 254);
            out_value = $urandom_range(in_value + 1, 255);
          end else if (pick == 1) begin
            in_value  = $urandom_range(16, 255);
            out_value = $urandom_range(1, in_value);
          end else begin
            in_value  = $urandom_range(1, 12);
            out_value = $urandom_range(1, in_value);
          end
        end
      endcase
      set_rates(fds_pkg::RATE_W'(in_value), fds_pkg::RATE_W'(out_value));
      if (phase == 2 || phase == 13) begin
        holds_asked <= holds_asked + 1;
      end
      send_random_items($urandom_range(30, 55));
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
